// ----- src/accel_tilt_pitch_roll_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef ACCEL_TILT_PITCH_ROLL_ASSERT_SVH
`define ACCEL_TILT_PITCH_ROLL_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define ATPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ATPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/atpr_pkg.sv -----
package atpr_pkg;

  // Number of entries in the arctangent table.
  localparam int TableLen = 24;
  // Fraction bits of the internal angle sum.
  localparam int IntFrac = 16;
  // Width of the CORDIC datapath.
  localparam int CordW = 44;
  // Width of the angle accumulator.
  localparam int AngW = 26;
  // Width of the squared-magnitude sum.
  localparam int Den2W = 32;
  // Width of the square root result.
  localparam int RootW = 24;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [AngW-1:0] ang_t;

  // Ninety degrees in internal angle units.
  localparam ang_t Ang90 = ang_t'(90 * 65536);

  // Arctangent of 2^-i in degrees times 2^16.
  function automatic ang_t atan_tab(input int i);
    ang_t r;
    r = '0;
    case (i)
      0: r = 26'd2949120;  1: r = 26'd1740967;  2: r = 26'd919879;
      3: r = 26'd466945;   4: r = 26'd234379;   5: r = 26'd117304;
      6: r = 26'd58666;    7: r = 26'd29335;    8: r = 26'd14668;
      9: r = 26'd7334;     10: r = 26'd3667;    11: r = 26'd1833;
      12: r = 26'd917;     13: r = 26'd458;     14: r = 26'd229;
      15: r = 26'd115;     16: r = 26'd57;      17: r = 26'd29;
      18: r = 26'd14;      19: r = 26'd7;       20: r = 26'd4;
      21: r = 26'd2;       22: r = 26'd1;       default: r = '0;
    endcase
    return r;
  endfunction

  // Sideband that travels with one angle lane.
  typedef struct packed {
    logic neg;
    logic num_zero;
    logic den_zero;
  } lane_flags_t;

endpackage

// ----- src/accel_tilt_pitch_roll.sv -----
// Channel | Dir | tdata (low bit first)            | tuser
// s_axis  | in  | accel_x, accel_y, accel_z (48b)  | -
// m_axis  | out | pitch_angle, roll_angle (32b)    | zero_vector
//
// The pipeline is a squares stage, 24 root stages, CORDIC_STAGES (capped at 24) CORDIC stages and an output stage.
// One word is accepted every cycle while m_axis is not stalled; the root and CORDIC stage chains set depth.
// rst_ni clears only the valid bits of the pipeline.
// A stall on m_axis holds every stage; s_axis_tready follows the output stage.
module accel_tilt_pitch_roll #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pitch_angle, roll_angle
  output logic        m_axis_tuser    // zero_vector
);
  import atpr_pkg::*;

  localparam int NStg = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
  localparam int Lat  = NStg + RootW + 2;

  logic signed [15:0] ax, ay, az, pitch, roll;
  logic en;
  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] zv_q;

  assign ax = s_axis_tdata[15:0];
  assign ay = s_axis_tdata[31:16];
  assign az = s_axis_tdata[47:32];

  // Pipeline advances when the output is empty or being taken.
  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;

  // Valid and zero flag shift registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) zv_q <= {zv_q[Lat-2:0], (ax == '0) && (ay == '0) && (az == '0)};
  end

  atpr_lane #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
    .clk_i(clk_i), .en_i(en),
    .num_i(ax), .a_i(ay), .b_i(az), .angle_o(pitch)
  );

  atpr_lane #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk_i(clk_i), .en_i(en),
    .num_i(ay), .a_i(ax), .b_i(az), .angle_o(roll)
  );

  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {roll, pitch};
  assign m_axis_tuser  = zv_q[Lat-1];

  `include "accel_tilt_pitch_roll_assert.svh"

  // A zero sample always reports zero angles.
  `ATPR_ASSERT_IMP(a_zero_angles, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "zero vector with nonzero angle")
  // A stalled output word holds.
  `ATPR_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")

endmodule

// ----- src/atpr_lane.sv -----
// One angle lane: squares, pipelined root, pipelined vectoring CORDIC, rounding.
// A shared enable advances every stage at once; the lane flags travel with the data.
module atpr_lane #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [15:0]  num_i,
  input  logic signed [15:0]  a_i,
  input  logic signed [15:0]  b_i,
  output logic signed [15:0]  angle_o
);
  import atpr_pkg::*;

  localparam int NStg  = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
  localparam int RStg  = RootW;
  localparam int Shift = IntFrac - ANGLE_FRAC_BITS;

  // Stage 1: squares and magnitude of the numerator.
  logic [Den2W-1:0]   den2_q;
  logic [15:0]        mag1_q;
  lane_flags_t        fl1_q;
  logic [Den2W-1:0]   den2_d;
  logic signed [31:0] asq_d;
  logic signed [31:0] bsq_d;

  always_comb begin
    asq_d  = a_i * a_i;
    bsq_d  = b_i * b_i;
    den2_d = Den2W'($unsigned(asq_d)) + Den2W'($unsigned(bsq_d));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den2_q          <= den2_d;
      mag1_q          <= num_i[15] ? 16'(-num_i) : num_i;
      fl1_q.neg       <= num_i[15];
      fl1_q.num_zero  <= (num_i == '0);
      fl1_q.den_zero  <= (den2_d == '0);
    end
  end

  // Root stages: one result bit per stage of floor(sqrt(den2 * 2^16)).
  localparam int RemW = RootW + 2;
  logic [2*RootW-1:0] rv_q  [RStg+1];
  logic [RemW-1:0]    rem_q [RStg+1];
  logic [RootW-1:0]   rt_q  [RStg+1];
  logic [15:0]        rmag_q[RStg+1];
  lane_flags_t        rfl_q [RStg+1];

  always_comb begin
    rv_q[0]   = {den2_q, 16'd0};
    rem_q[0]  = '0;
    rt_q[0]   = '0;
    rmag_q[0] = mag1_q;
    rfl_q[0]  = fl1_q;
  end

  for (genvar k = 0; k < RStg; k++) begin : g_root
    logic [RemW-1:0] trial;
    logic [RemW-1:0] rsh;
    always_comb begin
      rsh   = {rem_q[k][RemW-3:0], rv_q[k][2*RootW-1 -: 2]};
      trial = {rt_q[k], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rv_q[k+1]   <= {rv_q[k][2*RootW-3:0], 2'b00};
        rem_q[k+1]  <= (rsh >= trial) ? (rsh - trial) : rsh;
        rt_q[k+1]   <= {rt_q[k][RootW-2:0], (rsh >= trial)};
        rmag_q[k+1] <= rmag_q[k];
        rfl_q[k+1]  <= rfl_q[k];
      end
    end
  end

  // CORDIC stages: one rotation per stage.
  cord_t       cx_q [NStg+1];
  cord_t       cy_q [NStg+1];
  ang_t        an_q [NStg+1];
  lane_flags_t cfl_q[NStg+1];

  always_comb begin
    cx_q[0]  = cord_t'({1'b0, rt_q[RStg]});
    cy_q[0]  = cord_t'({1'b0, rmag_q[RStg], 8'd0});
    an_q[0]  = '0;
    cfl_q[0] = rfl_q[RStg];
  end

  for (genvar i = 0; i < NStg; i++) begin : g_cord
    cord_t sx, sy;
    always_comb begin
      sx = cx_q[i] >>> i;
      sy = cy_q[i] >>> i;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_q[i][CordW-1]) begin
          cx_q[i+1] <= cx_q[i] + sy;
          cy_q[i+1] <= cy_q[i] - sx;
          an_q[i+1] <= an_q[i] + atan_tab(i);
        end else begin
          cx_q[i+1] <= cx_q[i] - sy;
          cy_q[i+1] <= cy_q[i] + sx;
          an_q[i+1] <= an_q[i] - atan_tab(i);
        end
        cfl_q[i+1] <= cfl_q[i];
      end
    end
  end

  // Final stage: clamp, special cases, round, sign and saturate.
  ang_t        full;
  logic signed [AngW:0] res;
  logic signed [15:0]   ang_d;
  lane_flags_t fl;

  always_comb begin
    fl   = cfl_q[NStg];
    full = an_q[NStg];
    if (full[AngW-1]) full = '0;
    if (full > Ang90) full = Ang90;
    if (fl.den_zero) full = Ang90;
    res = (AngW+1)'((full + ang_t'(1 << (Shift - 1))) >>> Shift);
    if (fl.neg) res = -res;
    if (res > 32767) ang_d = 16'sd32767;
    else if (res < -32768) ang_d = -16'sd32768;
    else ang_d = res[15:0];
    if (fl.num_zero) ang_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) angle_o <= ang_d;
  end

endmodule
